@@ hdl/sfcd_pkg.sv @@
// Shared types and constants for the sensor frame checker and decoder.
package sfcd_pkg;

   localparam int FRAME_BYTES_DEF = 20;
   localparam int LEN_EXT_W       = 9;
   localparam int LEN_BIAS        = 5;
   localparam int FLAGS_POS       = 2;
   localparam int LEN_POS         = 3;
   localparam int VAL0_HI_POS     = 4;
   localparam int VAL0_LO_POS     = 5;
   localparam int VAL1_HI_POS     = 6;
   localparam int VAL1_LO_POS     = 7;
   localparam int FLAG_TEMP_BIT   = 0;
   localparam int FLAG_HUM_BIT    = 1;
   localparam int RSP_DATA_W      = 40;

   typedef enum logic [1:0] {
      STAT_GOOD     = 2'd0,
      STAT_TOO_LONG = 2'd1,
      STAT_BAD_SUM  = 2'd2
   } status_type;

   typedef enum logic {
      ACT_BYTE = 1'b0,
      ACT_END  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN_RD,
      ST_LEN_CHK,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

@@ hdl/sensor_frame_checker_decoder_unit.sv @@
// Top level: frame store, checksum sequencer and sensor value decoder.
//
//  channel | dir | tdata                                  | tuser
//  req     | in  | [7:0] rx_byte                          | [0] action
//  rsp     | out | status, temp_upd, temp, hum_upd, hum   | -
//
// A received byte is taken only in the idle state. An end marker starts a walk of len bytes
// (len = byte3 + 5, at most FRAME_BYTES); a too-long frame skips the walk. The single read
// port of the frame store is walked one byte per cycle by the checksum adder.
// Synchronous reset clears control, the store valid bits and the kept values.
// One result waits in the output register; the block stays in its final step while it is full.
module sensor_frame_checker_decoder_unit #(
   parameter int FRAME_BYTES = sfcd_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] rx_byte
   input  logic                          req_tuser,  // [0] action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] status, [2] temp_updated, [18:3] temperature, [19] hum_updated,
   // [35:20] humidity, [39:36] zero
   output logic [sfcd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sfcd_pkg::*;

   localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
   localparam int ADDR_W = $clog2(FRAME_BYTES);

   state_type               state_ff, state_in;
   logic [7:0]              mem [FRAME_BYTES];
   logic [FRAME_BYTES-1:0]  valid_ff;
   logic [7:0]              rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [LEN_W-1:0]        wpos_ff, wpos_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic [LEN_W-1:0]        pidx_ff, pidx_in;
   logic [7:0]              sum_ff, sum_in;
   logic                    match_ff, match_in;
   logic                    too_long_ff, too_long_in;
   logic [7:0]              flags_ff, flags_in;
   logic [7:0]              b4_ff, b4_in, b5_ff, b5_in, b6_ff, b6_in, b7_ff, b7_in;
   logic [15:0]             temp_ff, temp_in, hum_ff, hum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [LEN_EXT_W-1:0]    len_ext;
   logic                    req_fire;
   logic                    t_up, h_up;
   status_type              status;
   logic [15:0]             temp_new, hum_new;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_en      = req_fire && (action_type'(req_tuser) == ACT_BYTE)
                       && (wpos_ff < LEN_W'(FRAME_BYTES));
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign len_ext    = {1'b0, rd_data_ff} + LEN_EXT_W'(LEN_BIAS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wpos_ff[ADDR_W-1:0]] <= req_tdata;
      end
      if (rd_addr < ADDR_W'(FRAME_BYTES - 1) || rd_addr == ADDR_W'(FRAME_BYTES - 1)) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 8'd0;
      end else begin
         rd_data_ff <= 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         wpos_ff      <= '0;
         temp_ff      <= '0;
         hum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         temp_ff      <= temp_in;
         hum_ff       <= hum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wpos_ff[ADDR_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      pidx_ff     <= pidx_in;
      sum_ff      <= sum_in;
      match_ff    <= match_in;
      too_long_ff <= too_long_in;
      flags_ff    <= flags_in;
      b4_ff       <= b4_in;
      b5_ff       <= b5_in;
      b6_ff       <= b6_in;
      b7_ff       <= b7_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      pidx_in      = pidx_ff;
      sum_in       = sum_ff;
      match_in     = match_ff;
      too_long_in  = too_long_ff;
      flags_in     = flags_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      b6_in        = b6_ff;
      b7_in        = b7_ff;
      temp_in      = temp_ff;
      hum_in       = hum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_addr      = cnt_ff[ADDR_W-1:0];
      t_up         = 1'b0;
      h_up         = 1'b0;
      status       = STAT_GOOD;
      temp_new     = {b4_ff, b5_ff};
      hum_new      = flags_ff[FLAG_TEMP_BIT] ? {b6_ff, b7_ff} : {b4_ff, b5_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (action_type'(req_tuser) == ACT_END) begin
                  wpos_in  = '0;
                  state_in = ST_LEN_RD;
               end else if (wr_en) begin
                  wpos_in = wpos_ff + LEN_W'(1);
               end
            end
         end
         ST_LEN_RD: begin
            rd_addr  = ADDR_W'(LEN_POS);
            state_in = ST_LEN_CHK;
         end
         ST_LEN_CHK: begin
            too_long_in = len_ext > LEN_EXT_W'(FRAME_BYTES);
            len_in      = len_ext[LEN_W-1:0];
            match_in    = 1'b0;
            sum_in      = 8'd0;
            b5_in       = 8'd0;
            b6_in       = 8'd0;
            b7_in       = 8'd0;
            rd_addr     = '0;
            pidx_in     = '0;
            cnt_in      = LEN_W'(1);
            state_in    = too_long_in ? ST_FINISH : ST_WALK;
         end
         ST_WALK: begin
            if (pidx_ff == len_ff - LEN_W'(1)) begin
               match_in = (sum_ff == rd_data_ff);
            end else begin
               sum_in = sum_ff + rd_data_ff;
            end
            if (pidx_ff == LEN_W'(FLAGS_POS))   flags_in = rd_data_ff;
            if (pidx_ff == LEN_W'(VAL0_HI_POS)) b4_in    = rd_data_ff;
            if (pidx_ff == LEN_W'(VAL0_LO_POS)) b5_in    = rd_data_ff;
            if (pidx_ff == LEN_W'(VAL1_HI_POS)) b6_in    = rd_data_ff;
            if (pidx_ff == LEN_W'(VAL1_LO_POS)) b7_in    = rd_data_ff;
            if (cnt_ff < len_ff) begin
               rd_addr = cnt_ff[ADDR_W-1:0];
               pidx_in = cnt_ff;
               cnt_in  = cnt_ff + LEN_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (too_long_ff) begin
               status = STAT_TOO_LONG;
            end else if (!match_ff) begin
               status = STAT_BAD_SUM;
            end else begin
               status = STAT_GOOD;
               t_up   = flags_ff[FLAG_TEMP_BIT];
               h_up   = flags_ff[FLAG_HUM_BIT];
            end
            if (!rsp_valid_ff || rsp_tready) begin
               if (t_up) temp_in = temp_new;
               if (h_up) hum_in  = hum_new;
               rsp_data_in  = {4'd0, hum_in, h_up, temp_in, t_up, status};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/sfcd_checker.sv @@
// Port-level checker for the sensor frame checker and decoder, with its bind.
module sfcd_port_props (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [7:0]                    req_tdata,
   input logic                          req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sfcd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sfcd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("ready high right after end marker");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("undefined status code");

   a_reject_no_update: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STAT_GOOD |-> !rsp_tdata[2] && !rsp_tdata[19])
      else $error("rejected frame flagged an update");

   a_kept_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready ##1 rsp_tvalid && !rsp_tdata[2]
      |-> rsp_tdata[18:3] == $past(rsp_tdata[18:3]))
      else $error("kept temperature changed without update");

endmodule

bind sensor_frame_checker_decoder_unit sfcd_port_props u_sfcd_port_props (.*);

@@ tb/sv/sfcd_checker.sv @@
// Beat monitor, frame predictor and result comparator for the sensor frame decoder.
`timescale 1ns / 100ps

module sfcd_checker #(
   parameter int FRAME_BYTES = sfcd_pkg::FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   input  logic                            req_tuser,  // [0] action
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [sfcd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              mismatch_count,
   output int                              reports_pending
);
   import sfcd_pkg::*;

   typedef struct {
      status_type  status;
      logic        temp_upd;
      logic [15:0] temp;
      logic        hum_upd;
      logic [15:0] hum;
   } sensor_report_type;

   logic [7:0]        frame_mem [FRAME_BYTES];
   int                fill_pos;
   logic [15:0]       kept_temp;
   logic [15:0]       kept_hum;
   int                fail_tally;
   sensor_report_type report_q [$];

   initial begin
      fail_tally = 0;
   end

   // value bytes at or past the frame length read as zero
   function automatic logic [7:0] value_byte(int idx, int len);
      return (idx >= len || idx >= FRAME_BYTES) ? 8'h00 : frame_mem[idx];
   endfunction

   task automatic close_frame(output sensor_report_type rpt);
      int         len;
      int         off;
      logic [7:0] sum;
      logic [7:0] flags;
      rpt.status   = STAT_GOOD;
      rpt.temp_upd = 1'b0;
      rpt.hum_upd  = 1'b0;
      fill_pos     = 0;
      len = int'(frame_mem[LEN_POS]) + LEN_BIAS;
      if (len > FRAME_BYTES) begin
         rpt.status = STAT_TOO_LONG;
      end else begin
         sum = 8'h00;
         for (int i = 0; i < len - 1; i++) sum += frame_mem[i];
         if (sum != frame_mem[len-1]) begin
            rpt.status = STAT_BAD_SUM;
         end else begin
            flags = frame_mem[FLAGS_POS];
            off   = VAL0_HI_POS;
            if (flags[FLAG_TEMP_BIT]) begin
               kept_temp    = {value_byte(VAL0_HI_POS, len), value_byte(VAL0_LO_POS, len)};
               rpt.temp_upd = 1'b1;
               off          = VAL1_HI_POS;
            end
            if (flags[FLAG_HUM_BIT]) begin
               kept_hum    = {value_byte(off, len), value_byte(off + 1, len)};
               rpt.hum_upd = 1'b1;
            end
         end
      end
      rpt.temp = kept_temp;
      rpt.hum  = kept_hum;
   endtask

   function automatic int check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      sensor_report_type rpt;
      sensor_report_type want;
      if (reset) begin
         foreach (frame_mem[i]) frame_mem[i] = 8'h00;
         fill_pos  = 0;
         kept_temp = '0;
         kept_hum  = '0;
         report_q.delete();
      end else begin
         // result side first, so a beat in the same cycle as an end marker is not masked
         if (rsp_tvalid && rsp_tready) begin
            if (report_q.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               fail_tally++;
            end else begin
               want = report_q.pop_front();
               fail_tally += check_field("status", 16'(want.status), 16'(rsp_tdata[1:0]));
               fail_tally += check_field("temp_updated", 16'(want.temp_upd), 16'(rsp_tdata[2]));
               fail_tally += check_field("temperature", want.temp, rsp_tdata[18:3]);
               fail_tally += check_field("hum_updated", 16'(want.hum_upd), 16'(rsp_tdata[19]));
               fail_tally += check_field("humidity", want.hum, rsp_tdata[35:20]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_END) begin
               close_frame(rpt);
               report_q.push_back(rpt);
            end else if (fill_pos < FRAME_BYTES) begin
               frame_mem[fill_pos] = req_tdata;
               fill_pos++;
            end
         end
      end
      mismatch_count  <= fail_tally;
      reports_pending <= report_q.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top: clock, reset, beat stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;
   import sfcd_pkg::*;

   localparam int FRAME_BYTES  = FRAME_BYTES_DEF;
   localparam int ITEM_TARGET  = 1300;
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int SETTLE_TICKS = 2 * (FRAME_BYTES + 4);

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatch_count;
   int                    reports_pending;
   int                    items_sent;
   int                    stall_cycles;
   bit                    no_idle;
   bit                    long_hold_req;

   sensor_frame_checker_decoder_unit #(.FRAME_BYTES(FRAME_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sfcd_checker #(.FRAME_BYTES(FRAME_BYTES)) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random hold-off per result beat, one long hold on request
   initial begin
      int hold;
      bit long_done;
      long_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !long_done) begin
            hold      = LONG_HOLD;
            long_done = 1'b1;
         end else begin
            hold = no_idle ? 0 : $urandom_range(0, 10);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_beat(input action_type act, input logic [7:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_frame(input logic [7:0] fb[$], input bit add_sum);
      logic [7:0] sum;
      sum = 8'h00;
      foreach (fb[i]) begin
         sum += fb[i];
         send_beat(ACT_BYTE, fb[i]);
      end
      if (add_sum) send_beat(ACT_BYTE, sum);
      send_beat(ACT_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_frame();
      logic [7:0] fb[$];
      logic [7:0] sum;
      int         kind;
      int         len;
      int         n;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         len = $urandom_range(LEN_BIAS, FRAME_BYTES);
         for (int i = 0; i < len - 1; i++) fb.push_back(8'($urandom_range(0, 255)));
         fb[LEN_POS] = 8'(len - LEN_BIAS);
         sum = 8'h00;
         foreach (fb[i]) sum += fb[i];
         if (kind >= 60) sum ^= 8'($urandom_range(1, 255));
         fb.push_back(sum);
         // trailing bytes: dropped past the store, or stale filler inside it
         if (kind < 10) begin
            n = $urandom_range(1, 5);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 15) begin
            n = $urandom_range(1, 3);
            repeat (n) void'(fb.pop_back());
         end
      end else if (kind < 80) begin
         n = $urandom_range(4, 12);
         repeat (n) fb.push_back(8'($urandom_range(0, 255)));
         fb[LEN_POS] = 8'($urandom_range(16, 255));
      end else if (kind < 90) begin
         n = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6);
         repeat (n) fb.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(0, 6);
         repeat (n) fb.push_back(8'($urandom_range(0, 255)));
      end
      send_frame(fb, 1'b0);
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reports_pending != 0);
   endtask

   initial begin
      int target;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tuser     = ACT_BYTE;
      items_sent    = 0;
      no_idle       = 1'b0;
      long_hold_req = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // end marker on the cleared store
      send_beat(ACT_END, 8'hFF);
      // both values, extreme words
      send_frame('{8'hAA, 8'h55, 8'h03, 8'h05, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h12}, 1'b1);
      // humidity alone sits at bytes 4 and 5
      send_frame('{8'hFF, 8'h00, 8'h02, 8'h02, 8'h7F, 8'hFF}, 1'b1);
      // byte3 that would wrap an 8-bit length
      send_frame('{8'h00, 8'h00, 8'h00, 8'hFF}, 1'b0);
      // shortest frame, value bytes past the end read as zero
      send_frame('{8'h01, 8'h02, 8'h03, 8'h00}, 1'b1);
      pause_sender();

      for (int phase = 0; phase < 4; phase++) begin
         no_idle = (phase == 1);
         if (phase == 2) long_hold_req = 1'b1;
         target = items_sent + ITEM_TARGET / 4;
         while (items_sent < target) send_random_frame();
         pause_sender();
      end
      no_idle = 1'b0;

      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
